### src/logic_formula_tokenizer_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the formula tokenizer
// Shared property forms, all clocked on clock and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef LOGIC_FORMULA_TOKENIZER_TOP_ASSERT_SVH
`define LOGIC_FORMULA_TOKENIZER_TOP_ASSERT_SVH

// The condition holds at every clock edge out of reset.
`define LFT_ASSERT_HOLDS(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define LFT_ASSERT_IMPLIES(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define LFT_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### src/lft_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lft_pkg
// Token record, kind codes, character codes and the keyword and symbol
// matchers of the scanner; the token queue shares the token record and push bundle.
// ----------------------------------------------------------------------------
package lft_pkg;

   // Token kinds.
   localparam logic [3:0] KIND_FORALL  = 4'd0;
   localparam logic [3:0] KIND_EXISTS  = 4'd1;
   localparam logic [3:0] KIND_AND     = 4'd2;
   localparam logic [3:0] KIND_OR      = 4'd3;
   localparam logic [3:0] KIND_NOT     = 4'd4;
   localparam logic [3:0] KIND_IMPLIES = 4'd5;
   localparam logic [3:0] KIND_FALSUM  = 4'd6;
   localparam logic [3:0] KIND_IDENT   = 4'd7;
   localparam logic [3:0] KIND_LPAREN  = 4'd8;
   localparam logic [3:0] KIND_RPAREN  = 4'd9;
   localparam logic [3:0] KIND_DOT     = 4'd10;
   localparam logic [3:0] KIND_COMMA   = 4'd11;
   localparam logic [3:0] KIND_ERROR   = 4'd12;
   localparam logic [3:0] KIND_END     = 4'd13;

   // Character codes with a role of their own.
   localparam logic [7:0] CHAR_END        = 8'h00;
   localparam logic [7:0] CHAR_QMARK      = 8'h3F;
   localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
   localparam logic [7:0] CHAR_MINUS      = 8'h2D;
   localparam logic [7:0] CHAR_EQUAL      = 8'h3D;
   localparam logic [7:0] CHAR_GREATER    = 8'h3E;
   localparam logic [7:0] CHAR_LPAREN     = 8'h28;
   localparam logic [7:0] CHAR_RPAREN     = 8'h29;
   localparam logic [7:0] CHAR_DOT        = 8'h2E;
   localparam logic [7:0] CHAR_COMMA      = 8'h2C;
   localparam logic [7:0] UTF_LEAD_LONG   = 8'hE2;
   localparam logic [7:0] UTF_LEAD_SHORT  = 8'hC2;

   // Longest keyword, and most tokens one source byte can end.
   localparam int KEYWORD_LEN_MAX = 7;
   localparam int PUSH_MAX        = 3;

   typedef struct packed {
      logic [3:0]  token_kind;
      logic [15:0] token_offset;
      logic [15:0] token_length;
      logic        var_prefixed;
      logic [7:0]  error_byte;
      logic        last_of_run;
   } token_type;

   // Tokens ended by one accepted byte, in order, from scanner to queue.
   typedef struct packed {
      logic [1:0]                 count;
      token_type [PUSH_MAX-1:0]   slot;
   } push_type;

   typedef struct packed {
      logic       hit;
      logic [3:0] kind;
   } keyword_hit_type;

   typedef struct packed {
      logic       full;
      logic       partial;
      logic [3:0] kind;
   } symbol_hit_type;

   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return c == " " || (c >= 8'h09 && c <= 8'h0D);
   endfunction

   function automatic logic is_name_start(input logic [7:0] c);
      return is_alpha(c) || c == CHAR_UNDERSCORE;
   endfunction

   function automatic logic is_name_char(input logic [7:0] c);
      return is_alpha(c) || is_digit(c) || c == CHAR_UNDERSCORE;
   endfunction

   function automatic logic is_symbol_lead(input logic [7:0] c);
      return c == UTF_LEAD_LONG || c == UTF_LEAD_SHORT;
   endfunction

   function automatic token_type make_token(input logic [3:0] kind,
                                            input logic [15:0] offset,
                                            input logic [15:0] length,
                                            input logic variable,
                                            input logic [7:0] err);
      token_type t;
      t.token_kind   = kind;
      t.token_offset = offset;
      t.token_length = length;
      t.var_prefixed = variable;
      t.error_byte   = err;
      t.last_of_run  = 1'b0;
      return t;
   endfunction

   // prefix[0] is the first character of the name.
   function automatic keyword_hit_type keyword_lookup(
      input logic [KEYWORD_LEN_MAX-1:0][7:0] prefix, input logic [2:0] len);
      keyword_hit_type r;
      logic [15:0] w2;
      logic [23:0] w3;
      logic [47:0] w6;
      logic [55:0] w7;
      w2 = {prefix[0], prefix[1]};
      w3 = {prefix[0], prefix[1], prefix[2]};
      w6 = {prefix[0], prefix[1], prefix[2], prefix[3], prefix[4], prefix[5]};
      w7 = {prefix[0], prefix[1], prefix[2], prefix[3], prefix[4], prefix[5], prefix[6]};
      r.hit  = 1'b1;
      r.kind = KIND_IDENT;
      if (len == 3'd6 && w6 == "forall") r.kind = KIND_FORALL;
      else if (len == 3'd6 && w6 == "exists") r.kind = KIND_EXISTS;
      else if (len == 3'd3 && w3 == "and") r.kind = KIND_AND;
      else if (len == 3'd2 && w2 == "or") r.kind = KIND_OR;
      else if (len == 3'd3 && w3 == "not") r.kind = KIND_NOT;
      else if (len == 3'd7 && w7 == "implies") r.kind = KIND_IMPLIES;
      else if (len == 3'd3 && w3 == "bot") r.kind = KIND_FALSUM;
      else r.hit = 1'b0;
      return r;
   endfunction

   // Extends a held UTF-8 prefix (one or two bytes) by the byte c.
   function automatic symbol_hit_type symbol_step(input logic [7:0] held0,
                                                  input logic [7:0] held1,
                                                  input logic two_held,
                                                  input logic [7:0] c);
      symbol_hit_type r;
      r.full    = 1'b0;
      r.partial = 1'b0;
      r.kind    = KIND_ERROR;
      if (!two_held) begin
         if (held0 == UTF_LEAD_LONG) begin
            r.partial = (c == 8'h88) || (c == 8'h8A) || (c == 8'h87);
         end else if (held0 == UTF_LEAD_SHORT && c == 8'hAC) begin
            r.full = 1'b1;
            r.kind = KIND_NOT;
         end
      end else if (held0 == UTF_LEAD_LONG) begin
         case (held1)
            8'h88: begin
               r.full = 1'b1;
               case (c)
                  8'h80: r.kind = KIND_FORALL;
                  8'h83: r.kind = KIND_EXISTS;
                  8'hA7: r.kind = KIND_AND;
                  8'hA8: r.kind = KIND_OR;
                  default: r.full = 1'b0;
               endcase
            end
            8'h8A: begin
               r.full = (c == 8'hA5);
               r.kind = KIND_FALSUM;
            end
            8'h87: begin
               r.full = (c == 8'h92);
               r.kind = KIND_IMPLIES;
            end
            default: r.full = 1'b0;
         endcase
      end
      return r;
   endfunction

endpackage

### src/logic_formula_tokenizer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// logic_formula_tokenizer_top
// Tokenizer for first-order logic formulas, one source byte per request.
// ----------------------------------------------------------------------------
// The block takes one source byte per cycle while req_ready is high. The
// tokens that a byte ends enter the token queue and leave it in order, one
// per cycle on the result channel while rsp_ready is high; a byte ends zero
// to three tokens, and last_of_run marks the final one of that byte. Requests
// are taken back to back as long as the token queue (2**QUEUE_ADDR_BITS
// entries) has room for three more tokens, so the sustained rate is one byte
// per cycle whenever the bytes average at most one token each; the single
// result port, draining one token per cycle, is what sets the rate on
// token-dense text. Byte 0 ends the source and restarts the offset count.
module logic_formula_tokenizer_top import lft_pkg::*; #(
   parameter int POSITION_BITS   = 16,
   parameter int KEYWORD_MAX     = 7,
   parameter int QUEUE_ADDR_BITS = 3
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_text_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [3:0]  rsp_token_kind,
   output logic [15:0] rsp_token_offset,
   output logic [15:0] rsp_token_length,
   output logic        rsp_var_prefixed,
   output logic [7:0]  rsp_error_byte,
   output logic        rsp_last_of_run
);

   push_type  push;
   logic      room;
   token_type head;

   lft_scan #(
      .POSITION_BITS (POSITION_BITS),
      .KEYWORD_MAX   (KEYWORD_MAX)
   ) u_scan (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_text_byte (req_text_byte),
      .room          (room),
      .push          (push)
   );

   lft_queue #(
      .ADDR_BITS (QUEUE_ADDR_BITS)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_i     (push),
      .room       (room),
      .head_valid (rsp_valid),
      .head_ready (rsp_ready),
      .head       (head)
   );

   assign req_ready        = room;
   assign rsp_token_kind   = head.token_kind;
   assign rsp_token_offset = head.token_offset;
   assign rsp_token_length = head.token_length;
   assign rsp_var_prefixed = head.var_prefixed;
   assign rsp_error_byte   = head.error_byte;
   assign rsp_last_of_run  = head.last_of_run;

endmodule

### src/lft_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lft_scan
// Front end: takes one source byte per cycle while room is high, tracks
// the open token and passes the zero to three tokens it ends to the queue.
// ----------------------------------------------------------------------------
module lft_scan import lft_pkg::*; #(
   parameter int POSITION_BITS = 16,
   parameter int KEYWORD_MAX   = 7
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [7:0] req_text_byte,
   input  logic       room,
   output push_type   push
);

   `include "logic_formula_tokenizer_top_assert.svh"

   typedef enum logic [4:0] {
      MODE_IDLE  = 5'b00001,
      MODE_QMARK = 5'b00010,
      MODE_NAME  = 5'b00100,
      MODE_ARROW = 5'b01000,
      MODE_UTF   = 5'b10000
   } scan_mode_type;

   localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

   scan_mode_type            mode_ff, mode_in;
   logic [POSITION_BITS-1:0] pos_ff, pos_in;
   logic [POSITION_BITS-1:0] start_ff, start_in;
   logic [15:0]              name_len_ff, name_len_in;
   logic [1:0]               held_cnt_ff, held_cnt_in;
   logic                     marked_ff, marked_in;
   logic [7:0]               prefix_ff [KEYWORD_MAX];
   logic [7:0]               held_ff [2];

   logic        accept;
   logic [7:0]  c;
   logic        prefix_we, held0_we, held1_we;
   logic [15:0] prefix_sel;
   logic [POSITION_BITS-1:0] pos_inc, start_inc;
   logic [15:0] off_pos, off_start, off_start1;
   logic [KEYWORD_LEN_MAX-1:0][7:0] kw_prefix;
   keyword_hit_type kw;
   symbol_hit_type  sym;
   logic [3:0]  name_kind;
   token_type   pre_tok [2];
   token_type   fresh_tok;
   logic [1:0]  pre_n;
   logic        fresh_has;
   logic        do_fresh;

   function automatic logic [15:0] clamp_off(input logic [POSITION_BITS-1:0] v);
      logic [31:0] w;
      w = 32'(v);
      return (w > 32'h0000_FFFF) ? 16'hFFFF : w[15:0];
   endfunction

   assign accept = req_valid && room;
   assign c      = req_text_byte;

   assign pos_inc    = (pos_ff == POS_MAX) ? pos_ff : pos_ff + POSITION_BITS'(1);
   assign start_inc  = (start_ff == POS_MAX) ? start_ff : start_ff + POSITION_BITS'(1);
   assign off_pos    = clamp_off(pos_ff);
   assign off_start  = clamp_off(start_ff);
   assign off_start1 = clamp_off(start_inc);

   always_comb begin
      for (int i = 0; i < KEYWORD_LEN_MAX; i++) begin
         kw_prefix[i] = prefix_ff[i];
      end
   end

   assign kw  = keyword_lookup(kw_prefix, name_len_ff[2:0]);
   assign sym = symbol_step(held_ff[0], held_ff[1], held_cnt_ff == 2'd2, c);
   // A name that is too long, or that carried the prefix, is never a keyword.
   assign name_kind = (!marked_ff && name_len_ff <= 16'(KEYWORD_LEN_MAX) && kw.hit)
                      ? kw.kind : KIND_IDENT;

   always_comb begin
      mode_in     = mode_ff;
      pos_in      = pos_ff;
      start_in    = start_ff;
      name_len_in = name_len_ff;
      held_cnt_in = held_cnt_ff;
      marked_in   = marked_ff;
      prefix_we   = 1'b0;
      prefix_sel  = '0;
      held0_we    = 1'b0;
      held1_we    = 1'b0;
      pre_tok[0]  = '0;
      pre_tok[1]  = '0;
      pre_n       = 2'd0;
      fresh_tok   = '0;
      fresh_has   = 1'b0;
      do_fresh    = 1'b0;

      if (accept) begin
         pos_in = pos_inc;
         case (mode_ff)
            MODE_QMARK: begin
               if (is_name_start(c)) begin
                  mode_in     = MODE_NAME;
                  marked_in   = 1'b1;
                  start_in    = pos_ff;
                  name_len_in = 16'd1;
                  prefix_we   = 1'b1;
               end else begin
                  // A prefix with no name after it: zero-length error, then
                  // the byte is scanned again as if nothing were open.
                  pre_tok[0] = make_token(KIND_ERROR, off_pos, 16'd0, 1'b0, c);
                  pre_n      = 2'd1;
                  do_fresh   = 1'b1;
               end
            end
            MODE_NAME: begin
               if (is_name_char(c)) begin
                  prefix_we  = name_len_ff < 16'(KEYWORD_MAX);
                  prefix_sel = name_len_ff;
                  if (name_len_ff != 16'hFFFF) begin
                     name_len_in = name_len_ff + 16'd1;
                  end
               end else begin
                  pre_tok[0] = make_token(name_kind, off_start, name_len_ff,
                                          marked_ff, 8'h00);
                  pre_n      = 2'd1;
                  do_fresh   = 1'b1;
               end
            end
            MODE_ARROW: begin
               held_cnt_in = 2'd0;
               if (c == CHAR_GREATER) begin
                  pre_tok[0] = make_token(KIND_IMPLIES, off_start, 16'd2, 1'b0, 8'h00);
                  pre_n      = 2'd1;
                  mode_in    = MODE_IDLE;
               end else begin
                  pre_tok[0] = make_token(KIND_ERROR, off_start, 16'd1, 1'b0, held_ff[0]);
                  pre_n      = 2'd1;
                  do_fresh   = 1'b1;
               end
            end
            MODE_UTF: begin
               if (sym.full) begin
                  pre_tok[0]  = make_token(sym.kind, off_start,
                                           (held_cnt_ff == 2'd2) ? 16'd3 : 16'd2,
                                           1'b0, 8'h00);
                  pre_n       = 2'd1;
                  held_cnt_in = 2'd0;
                  mode_in     = MODE_IDLE;
               end else if (sym.partial && held_cnt_ff == 2'd1) begin
                  held1_we    = 1'b1;
                  held_cnt_in = 2'd2;
               end else begin
                  // Each held byte of the broken sequence becomes its own error.
                  pre_tok[0]  = make_token(KIND_ERROR, off_start, 16'd1, 1'b0, held_ff[0]);
                  pre_tok[1]  = make_token(KIND_ERROR, off_start1, 16'd1, 1'b0, held_ff[1]);
                  pre_n       = held_cnt_ff;
                  held_cnt_in = 2'd0;
                  do_fresh    = 1'b1;
               end
            end
            default: begin
               do_fresh = 1'b1;
            end
         endcase

         if (do_fresh) begin
            mode_in = MODE_IDLE;
            if (c == CHAR_END) begin
               fresh_tok   = make_token(KIND_END, 16'd0, 16'd0, 1'b0, 8'h00);
               fresh_has   = 1'b1;
               pos_in      = '0;
               start_in    = '0;
               name_len_in = '0;
               held_cnt_in = 2'd0;
               marked_in   = 1'b0;
            end else if (is_space(c)) begin
               mode_in = MODE_IDLE;
            end else if (c == CHAR_QMARK) begin
               mode_in = MODE_QMARK;
            end else if (is_name_start(c)) begin
               mode_in     = MODE_NAME;
               marked_in   = 1'b0;
               start_in    = pos_ff;
               name_len_in = 16'd1;
               prefix_we   = 1'b1;
               prefix_sel  = '0;
            end else if (c == CHAR_MINUS || c == CHAR_EQUAL) begin
               mode_in     = MODE_ARROW;
               held0_we    = 1'b1;
               held_cnt_in = 2'd1;
               start_in    = pos_ff;
            end else if (is_symbol_lead(c)) begin
               mode_in     = MODE_UTF;
               held0_we    = 1'b1;
               held_cnt_in = 2'd1;
               start_in    = pos_ff;
            end else begin
               fresh_has = 1'b1;
               case (c)
                  CHAR_LPAREN: fresh_tok = make_token(KIND_LPAREN, off_pos, 16'd1, 1'b0, 8'h00);
                  CHAR_RPAREN: fresh_tok = make_token(KIND_RPAREN, off_pos, 16'd1, 1'b0, 8'h00);
                  CHAR_DOT:    fresh_tok = make_token(KIND_DOT, off_pos, 16'd1, 1'b0, 8'h00);
                  CHAR_COMMA:  fresh_tok = make_token(KIND_COMMA, off_pos, 16'd1, 1'b0, 8'h00);
                  default:     fresh_tok = make_token(KIND_ERROR, off_pos, 16'd1, 1'b0, c);
               endcase
            end
         end
      end
   end

   // Pending tokens come first, the token of the rescanned byte after them.
   always_comb begin
      push.count = pre_n + 2'(fresh_has);
      push.slot[0] = (pre_n == 2'd0) ? fresh_tok : pre_tok[0];
      push.slot[1] = (pre_n == 2'd1) ? fresh_tok : pre_tok[1];
      push.slot[2] = fresh_tok;
      case (push.count)
         2'd1: push.slot[0].last_of_run = 1'b1;
         2'd2: push.slot[1].last_of_run = 1'b1;
         2'd3: push.slot[2].last_of_run = 1'b1;
         default: push.slot[0].last_of_run = push.slot[0].last_of_run;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_IDLE;
         pos_ff      <= '0;
         start_ff    <= '0;
         name_len_ff <= '0;
         held_cnt_ff <= 2'd0;
         marked_ff   <= 1'b0;
      end else begin
         mode_ff     <= mode_in;
         pos_ff      <= pos_in;
         start_ff    <= start_in;
         name_len_ff <= name_len_in;
         held_cnt_ff <= held_cnt_in;
         marked_ff   <= marked_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < KEYWORD_MAX; i++) begin
         if (prefix_we && prefix_sel == 16'(i)) begin
            prefix_ff[i] <= c;
         end
      end
      if (held0_we) begin
         held_ff[0] <= c;
      end
      if (held1_we) begin
         held_ff[1] <= c;
      end
   end

   `LFT_ASSERT_IMPLIES(a_two_held_only_in_utf, held_cnt_ff == 2'd2, mode_ff == MODE_UTF, "two held bytes outside a symbol")
   `LFT_ASSERT_IMPLIES(a_arrow_holds_one, mode_ff == MODE_ARROW, held_cnt_ff == 2'd1, "arrow start not held")
   `LFT_ASSERT_IMPLIES(a_no_push_when_idle, !accept, push.count == 2'd0, "tokens pushed without an accepted request")
   `LFT_ASSERT_NEXT(a_end_restarts, accept && c == CHAR_END, pos_ff == '0 && mode_ff == MODE_IDLE, "end of source did not clear the scanner")

endmodule

### src/lft_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lft_queue
// Back end: token queue that takes up to three tokens per cycle from the
// scanner and presents one token per cycle to a ready result channel.
// ----------------------------------------------------------------------------
module lft_queue import lft_pkg::*; #(
   parameter int ADDR_BITS = 3
) (
   input  logic      clock,
   input  logic      reset,
   input  push_type  push_i,
   output logic      room,
   output logic      head_valid,
   input  logic      head_ready,
   output token_type head
);

   `include "logic_formula_tokenizer_top_assert.svh"

   localparam int DEPTH = 1 << ADDR_BITS;

   token_type            mem_ff [DEPTH];
   logic [ADDR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [ADDR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [ADDR_BITS:0]   count_ff, count_in;
   logic                 pop;

   assign head_valid = count_ff != '0;
   assign head       = mem_ff[rd_ptr_ff];
   assign pop        = head_valid && head_ready;
   // Room for the worst burst one byte can cause.
   assign room       = count_ff <= (ADDR_BITS + 1)'(DEPTH - PUSH_MAX);

   assign wr_ptr_in = wr_ptr_ff + ADDR_BITS'(push_i.count);
   assign rd_ptr_in = rd_ptr_ff + ADDR_BITS'(pop);
   assign count_in  = count_ff + (ADDR_BITS + 1)'(push_i.count) - (ADDR_BITS + 1)'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < PUSH_MAX; j++) begin
         if (2'(j) < push_i.count) begin
            mem_ff[wr_ptr_ff + ADDR_BITS'(j)] <= push_i.slot[j];
         end
      end
   end

   `LFT_ASSERT_HOLDS(a_no_overflow, 32'(count_ff) + 32'(push_i.count) <= 32'(DEPTH), "token queue overflow")
   `LFT_ASSERT_NEXT(a_push_shows_head, count_ff == '0 && push_i.count != 2'd0, head_valid, "pushed token not presented")
   `LFT_ASSERT_IMPLIES(a_count_in_range, 1'b1, 32'(count_ff) <= 32'(DEPTH), "token count beyond queue depth")

endmodule

### dv/logic_formula_token_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// logic_formula_token_checker
// Watches the byte and token channels of the formula tokenizer, predicts the
// tokens that each accepted request ends and compares every token taken from
// the block with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module logic_formula_token_checker import lft_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [7:0]  req_text_byte,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [3:0]  rsp_token_kind,
   input  logic [15:0] rsp_token_offset,
   input  logic [15:0] rsp_token_length,
   input  logic        rsp_var_prefixed,
   input  logic [7:0]  rsp_error_byte,
   input  logic        rsp_last_of_run,
   output int          fail_count,
   output int          pending_tokens
);

   typedef enum logic [2:0] {
      SCAN_IDLE,
      SCAN_QMARK,
      SCAN_NAME,
      SCAN_ARROW,
      SCAN_SYMBOL
   } scan_mode_type;

   localparam logic [15:0] OFFSET_MAX   = 16'hFFFF;
   localparam int          REPORT_LIMIT = 10;
   localparam int          SYMBOL_COUNT = 7;

   // Multi-byte symbols, first byte in the top bits; the short one is padded.
   localparam logic [23:0] SYMBOL_SEQ [SYMBOL_COUNT] = '{
      24'hE28880, 24'hE28883, 24'hE288A7, 24'hE288A8,
      24'hC2AC00, 24'hE28AA5, 24'hE28792
   };
   localparam int SYMBOL_LEN [SYMBOL_COUNT] = '{3, 3, 3, 3, 2, 3, 3};
   localparam logic [3:0] SYMBOL_KIND [SYMBOL_COUNT] = '{
      KIND_FORALL, KIND_EXISTS, KIND_AND, KIND_OR, KIND_NOT, KIND_FALSUM, KIND_IMPLIES
   };

   scan_mode_type scan_mode;
   logic [15:0]   next_offset;
   logic [15:0]   token_start;
   logic [15:0]   name_len;
   logic [7:0]    name_head [KEYWORD_LEN_MAX];
   logic [7:0]    held_byte [2];
   int            held_count;
   logic          variable_mark;
   token_type     byte_tokens [$];
   token_type     expected_tokens [$];

   function automatic logic letter(input logic [7:0] c);
      return (c | 8'h20) >= "a" && (c | 8'h20) <= "z";
   endfunction

   function automatic logic name_start(input logic [7:0] c);
      return letter(c) || c == CHAR_UNDERSCORE;
   endfunction

   function automatic logic name_byte(input logic [7:0] c);
      return name_start(c) || (c >= "0" && c <= "9");
   endfunction

   function automatic logic blank(input logic [7:0] c);
      return c == " " || (c >= 8'h09 && c <= 8'h0D);
   endfunction

   function automatic logic [15:0] offset_plus(input logic [15:0] a, input int b);
      logic [16:0] s;
      s = {1'b0, a} + 17'(b);
      return s[16] ? OFFSET_MAX : s[15:0];
   endfunction

   // Keyword kind of the open name, or ident when it matches none, is too long or carries the prefix.
   function automatic logic [3:0] name_kind();
      logic [55:0] word;
      int i;
      word = '0;
      if (variable_mark || name_len > KEYWORD_LEN_MAX) return KIND_IDENT;
      for (i = 0; i < name_len; i++) word = {word[47:0], name_head[i]};
      case (word)
         56'("forall"):  return KIND_FORALL;
         56'("exists"):  return KIND_EXISTS;
         56'("and"):     return KIND_AND;
         56'("or"):      return KIND_OR;
         56'("not"):     return KIND_NOT;
         56'("implies"): return KIND_IMPLIES;
         56'("bot"):     return KIND_FALSUM;
         default:        return KIND_IDENT;
      endcase
   endfunction

   function automatic string token_text(input token_type t);
      return $sformatf("kind=%0d offset=%0d length=%0d var=%0b err=%02h last=%0b",
                       t.token_kind, t.token_offset, t.token_length, t.var_prefixed,
                       t.error_byte, t.last_of_run);
   endfunction

   task automatic clear_scan();
      scan_mode     = SCAN_IDLE;
      next_offset   = '0;
      token_start   = '0;
      name_len      = '0;
      held_count    = 0;
      variable_mark = 1'b0;
      foreach (name_head[i]) name_head[i] = '0;
      foreach (held_byte[i]) held_byte[i] = '0;
   endtask

   task automatic add_token(input logic [3:0] kind, input logic [15:0] offset,
                            input logic [15:0] length, input logic variable,
                            input logic [7:0] err);
      token_type t;
      t.token_kind   = kind;
      t.token_offset = offset;
      t.token_length = length;
      t.var_prefixed = variable;
      t.error_byte   = err;
      t.last_of_run  = 1'b0;
      byte_tokens.push_back(t);
   endtask

   task automatic open_name(input logic [7:0] c, input logic [15:0] pos, input logic variable);
      scan_mode     = SCAN_NAME;
      variable_mark = variable;
      token_start   = pos;
      name_len      = 16'd1;
      name_head[0]  = c;
   endtask

   // Each byte of a failed partial match becomes an error token of its own.
   task automatic flush_held();
      int i;
      for (i = 0; i < held_count; i++)
         add_token(KIND_ERROR, offset_plus(token_start, i), 16'd1, 1'b0, held_byte[i]);
      held_count = 0;
      scan_mode  = SCAN_IDLE;
   endtask

   // Handles a byte as if no token were open.
   task automatic start_fresh(input logic [7:0] c, input logic [15:0] pos);
      scan_mode = SCAN_IDLE;
      if (c == CHAR_END) begin
         add_token(KIND_END, '0, '0, 1'b0, '0);
         clear_scan();
      end else if (blank(c)) begin
      end else if (c == CHAR_QMARK) begin
         scan_mode = SCAN_QMARK;
      end else if (name_start(c)) begin
         open_name(c, pos, 1'b0);
      end else if (c == CHAR_MINUS || c == CHAR_EQUAL) begin
         scan_mode    = SCAN_ARROW;
         held_byte[0] = c;
         held_count   = 1;
         token_start  = pos;
      end else if (c == UTF_LEAD_LONG || c == UTF_LEAD_SHORT) begin
         scan_mode    = SCAN_SYMBOL;
         held_byte[0] = c;
         held_count   = 1;
         token_start  = pos;
      end else begin
         case (c)
            CHAR_LPAREN: add_token(KIND_LPAREN, pos, 16'd1, 1'b0, '0);
            CHAR_RPAREN: add_token(KIND_RPAREN, pos, 16'd1, 1'b0, '0);
            CHAR_DOT:    add_token(KIND_DOT, pos, 16'd1, 1'b0, '0);
            CHAR_COMMA:  add_token(KIND_COMMA, pos, 16'd1, 1'b0, '0);
            default:     add_token(KIND_ERROR, pos, 16'd1, 1'b0, c);
         endcase
      end
   endtask

   task automatic predict_byte(input logic [7:0] c);
      logic [15:0] pos;
      logic [3:0]  kind;
      logic        found_full;
      logic        partial;
      logic        match;
      int          i;
      int          j;
      token_type   last;
      pos         = next_offset;
      next_offset = offset_plus(next_offset, 1);
      byte_tokens.delete();
      case (scan_mode)
         SCAN_QMARK: begin
            if (name_start(c)) begin
               open_name(c, pos, 1'b1);
            end else begin
               add_token(KIND_ERROR, pos, '0, 1'b0, c);
               start_fresh(c, pos);
            end
         end
         SCAN_NAME: begin
            if (name_byte(c)) begin
               if (name_len < KEYWORD_LEN_MAX) name_head[name_len] = c;
               if (name_len < OFFSET_MAX) name_len++;
            end else begin
               kind = name_kind();
               add_token(kind, token_start, name_len,
                         kind == KIND_IDENT ? variable_mark : 1'b0, '0);
               scan_mode = SCAN_IDLE;
               start_fresh(c, pos);
            end
         end
         SCAN_ARROW: begin
            if (c == CHAR_GREATER) begin
               add_token(KIND_IMPLIES, token_start, 16'd2, 1'b0, '0);
               held_count = 0;
               scan_mode  = SCAN_IDLE;
            end else begin
               flush_held();
               start_fresh(c, pos);
            end
         end
         SCAN_SYMBOL: begin
            kind       = KIND_ERROR;
            found_full = 1'b0;
            partial    = 1'b0;
            for (i = 0; i < SYMBOL_COUNT; i++) begin
               if (SYMBOL_LEN[i] > held_count) begin
                  match = 1'b1;
                  for (j = 0; j < held_count; j++)
                     if (SYMBOL_SEQ[i][23-8*j -: 8] != held_byte[j]) match = 1'b0;
                  if (match && SYMBOL_SEQ[i][23-8*held_count -: 8] == c) begin
                     if (SYMBOL_LEN[i] == held_count + 1) begin
                        found_full = 1'b1;
                        kind       = SYMBOL_KIND[i];
                     end else begin
                        partial = 1'b1;
                     end
                  end
               end
            end
            if (found_full) begin
               add_token(kind, token_start, 16'(held_count + 1), 1'b0, '0);
               held_count = 0;
               scan_mode  = SCAN_IDLE;
            end else if (partial && held_count < 2) begin
               held_byte[held_count] = c;
               held_count++;
            end else begin
               flush_held();
               start_fresh(c, pos);
            end
         end
         default: start_fresh(c, pos);
      endcase
      if (byte_tokens.size() > 0) begin
         last = byte_tokens.pop_back();
         last.last_of_run = 1'b1;
         byte_tokens.push_back(last);
      end
      foreach (byte_tokens[i]) expected_tokens.push_back(byte_tokens[i]);
   endtask

   always @(posedge clock) begin
      token_type seen;
      token_type want;
      if (reset) begin
         clear_scan();
         expected_tokens.delete();
         fail_count = 0;
      end else begin
         // A token never leaves on the edge that takes its request, so the
         // result side is checked first.
         if (rsp_valid && rsp_ready) begin
            seen = {rsp_token_kind, rsp_token_offset, rsp_token_length, rsp_var_prefixed,
                    rsp_error_byte, rsp_last_of_run};
            if (expected_tokens.size() == 0) begin
               fail_count++;
               if (fail_count <= REPORT_LIMIT)
                  $display("%0t: token with none expected: %s", $realtime, token_text(seen));
            end else begin
               want = expected_tokens.pop_front();
               if (seen.token_kind !== want.token_kind
                   || seen.token_offset !== want.token_offset
                   || seen.token_length !== want.token_length
                   || seen.var_prefixed !== want.var_prefixed
                   || seen.error_byte !== want.error_byte
                   || seen.last_of_run !== want.last_of_run) begin
                  fail_count++;
                  if (fail_count <= REPORT_LIMIT)
                     $display("%0t: token mismatch\n   expected %s\n   actual   %s",
                              $realtime, token_text(want), token_text(seen));
               end
            end
         end
         if (req_valid && req_ready) predict_byte(req_text_byte);
      end
      pending_tokens = expected_tokens.size();
   end

endmodule

### dv/tb_logic_formula_tokenizer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_logic_formula_tokenizer_top
// Feeds the formula tokenizer a short hand-written source, a name longer than
// any keyword, and random formulas mixed with noise, under random idling on
// both channels and one long result stall.
// ----------------------------------------------------------------------------
module tb_logic_formula_tokenizer_top import lft_pkg::*; ();

   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int RANDOM_BYTES    = 80;
   localparam int CALM_TAIL       = 30;
   localparam int HOLD_CYCLES     = 80;
   localparam int DENSE_BYTES     = 24;
   localparam int LONG_NAME_BYTES = 10;
   localparam int DRAIN_CYCLES    = 20;

   // Covers variables, the bare prefix, both symbol lengths, arrows, broken
   // sequences, stray bytes, a keyword and the end of source inside a prefix.
   localparam logic [7:0] OPENING [27] = '{
      CHAR_QMARK, "x", CHAR_DOT,
      CHAR_QMARK, CHAR_LPAREN,
      8'hE2, 8'h88, 8'h80,
      8'hC2, 8'hAC,
      CHAR_MINUS, CHAR_GREATER,
      CHAR_EQUAL, "9",
      8'hE2, 8'h87, CHAR_RPAREN,
      8'hFF, 8'h80,
      "a", "n", "d", CHAR_COMMA,
      8'h09, CHAR_QMARK, CHAR_END, CHAR_END
   };

   localparam logic [7:0] PUNCTUATION [4] = '{CHAR_LPAREN, CHAR_RPAREN, CHAR_DOT, CHAR_COMMA};

   localparam logic [23:0] SYMBOLS [7] = '{
      24'hE28880, 24'hE28883, 24'hE288A7, 24'hE288A8,
      24'hC2AC00, 24'hE28AA5, 24'hE28792
   };

   string keyword_list [7] = '{"forall", "exists", "and", "or", "not", "implies", "bot"};

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_text_byte = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [3:0]  rsp_token_kind;
   logic [15:0] rsp_token_offset;
   logic [15:0] rsp_token_length;
   logic        rsp_var_prefixed;
   logic [7:0]  rsp_error_byte;
   logic        rsp_last_of_run;

   int fail_count;
   int pending_tokens;
   int bytes_sent = 0;
   int quiet_cycles = 0;
   bit idle_on = 1'b0;
   bit hold_request = 1'b0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   logic_formula_tokenizer_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_text_byte    (req_text_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_token_kind   (rsp_token_kind),
      .rsp_token_offset (rsp_token_offset),
      .rsp_token_length (rsp_token_length),
      .rsp_var_prefixed (rsp_var_prefixed),
      .rsp_error_byte   (rsp_error_byte),
      .rsp_last_of_run  (rsp_last_of_run)
   );

   logic_formula_token_checker token_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_text_byte    (req_text_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_token_kind   (rsp_token_kind),
      .rsp_token_offset (rsp_token_offset),
      .rsp_token_length (rsp_token_length),
      .rsp_var_prefixed (rsp_var_prefixed),
      .rsp_error_byte   (rsp_error_byte),
      .rsp_last_of_run  (rsp_last_of_run),
      .fail_count       (fail_count),
      .pending_tokens   (pending_tokens)
   );

   // Called at a falling edge; returns at the falling edge after acceptance
   // with valid still high, so the next request follows back to back.
   task automatic send_byte(input logic [7:0] b);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_text_byte <= b;
      do @(posedge clock); while (!req_ready);
      bytes_sent++;
      @(negedge clock);
   endtask

   function automatic logic [7:0] random_name_byte(input bit first);
      int r;
      r = $urandom_range(0, first ? 52 : 62);
      if (r < 26) return 8'("a" + r);
      if (r < 52) return 8'("A" + r - 26);
      if (r == 52) return CHAR_UNDERSCORE;
      return 8'("0" + r - 53);
   endfunction

   task automatic send_word(input string word);
      int i;
      for (i = 0; i < word.len(); i++) send_byte(word[i]);
   endtask

   // Mostly pieces of well-formed formulas; the rest is noise and broken
   // multi-byte sequences.
   task automatic send_random_piece();
      int          i;
      int          n;
      logic [23:0] sym;
      case ($urandom_range(0, 19))
         0, 1, 2, 3: begin
            if ($urandom_range(0, 3) == 0) send_byte(CHAR_QMARK);
            send_word(keyword_list[$urandom_range(0, 6)]);
            if ($urandom_range(0, 1) == 1) send_byte(" ");
         end
         17: begin
            // A keyword that runs on into a longer name.
            send_word(keyword_list[$urandom_range(0, 6)]);
            send_byte(random_name_byte(1'b0));
            send_byte(" ");
         end
         4, 5, 18, 19: begin
            if ($urandom_range(0, 2) == 0) send_byte(CHAR_QMARK);
            n = $urandom_range(1, 9);
            send_byte(random_name_byte(1'b1));
            for (i = 1; i < n; i++) send_byte(random_name_byte(1'b0));
            if ($urandom_range(0, 1) == 1) send_byte(" ");
         end
         6: begin
            send_byte($urandom_range(0, 1) == 1 ? CHAR_MINUS : CHAR_EQUAL);
            send_byte(CHAR_GREATER);
         end
         7, 8: begin
            sym = SYMBOLS[$urandom_range(0, 6)];
            send_byte(sym[23:16]);
            send_byte(sym[15:8]);
            if (sym[7:0] != 8'h00) send_byte(sym[7:0]);
         end
         9, 10, 11: send_byte(PUNCTUATION[$urandom_range(0, 3)]);
         12: begin
            n = $urandom_range(1, 3);
            for (i = 0; i < n; i++)
               send_byte($urandom_range(0, 5) == 0 ? 8'(" ") : 8'($urandom_range(9, 13)));
         end
         13: send_byte(8'($urandom_range(1, 255)));
         14: begin
            case ($urandom_range(0, 3))
               0: send_byte(UTF_LEAD_LONG);
               1: begin
                  send_byte(UTF_LEAD_LONG);
                  send_byte(SYMBOLS[$urandom_range(0, 6)][15:8]);
               end
               2: send_byte(UTF_LEAD_SHORT);
               default: send_byte($urandom_range(0, 1) == 1 ? CHAR_MINUS : CHAR_EQUAL);
            endcase
            send_byte(8'($urandom_range(1, 255)));
         end
         15: begin
            send_byte(CHAR_QMARK);
            send_byte(8'($urandom_range(1, 255)));
         end
         default: send_byte($urandom_range(0, 2) == 0 ? CHAR_END : 8'(" "));
      endcase
   endtask

   initial begin : receiver
      int stall_left;
      int hold_left;
      stall_left = 0;
      hold_left  = 0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (!idle_on) begin
            rsp_ready <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if ($urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(0, 11);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_logic_formula_tokenizer_top: FAIL");
         $finish;
      end
   end

   initial begin : stimulus
      int random_start;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      idle_on = 1'b1;
      foreach (OPENING[i]) send_byte(OPENING[i]);

      // A name too long to be a keyword, then a lone minus broken off by a
      // name byte, and the end of source.
      idle_on = 1'b0;
      send_byte("a");
      repeat (LONG_NAME_BYTES) send_byte("b");
      send_byte(CHAR_LPAREN);
      send_byte(CHAR_MINUS);
      send_byte("x");
      send_byte(CHAR_END);

      // Token-dense burst while the receiver holds off, so the queue fills.
      idle_on      = 1'b1;
      random_start = bytes_sent;
      hold_request = 1'b1;
      repeat (DENSE_BYTES) send_byte(PUNCTUATION[$urandom_range(0, 3)]);

      while (bytes_sent < random_start + RANDOM_BYTES) begin
         if (bytes_sent >= random_start + RANDOM_BYTES - CALM_TAIL) idle_on = 1'b0;
         send_random_piece();
      end
      send_byte(CHAR_END);
      req_valid <= 1'b0;

      do @(negedge clock); while (pending_tokens != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb_logic_formula_tokenizer_top: PASS");
      end else begin
         $display("tb_logic_formula_tokenizer_top: FAIL");
      end
      $finish;
   end

endmodule
